### hw/rtl/skc_pkg.sv
// Shared types and constants of the selected k-mer counter.
// No dependencies; used by skc_window and selected_kmer_counter.
package skc_pkg;

  localparam int unsigned KeyBits = 64;
  localparam int unsigned LenBits = 6;
  localparam logic [LenBits-1:0] KLenReset = 6'd22;
  localparam logic [LenBits-1:0] KLenMax = 6'd32;

  localparam logic [7:0] ChHeader = 8'h3E; // '>'
  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChN = 8'h4E;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeStream = 2'd1;
  localparam logic [1:0] ModeRead = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusDrop = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] load_key;
    logic [7:0]  text_byte;
    logic [9:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] window_value;
    logic        window_full;
    logic [63:0] entry_key;
    logic [31:0] entry_count;
    logic        entry_valid;
  } out_item_t;

  // window unit status seen by the controller
  typedef struct packed {
    logic [KeyBits-1:0] window;
    logic [KeyBits-1:0] rev_comp;
    logic               full;
    logic               shifted;
  } win_stat_t;

endpackage

### hw/rtl/skc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module skc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/skc_window.sv
// FASTA byte parser and rolling 2-bit k-mer window with reverse complement.
// Depends on skc_pkg.
module skc_window (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [5:0]              cfg_len_i,
  input  logic                    byte_we_i,
  input  logic [7:0]              text_byte_i,
  output skc_pkg::win_stat_t      stat_o
);
  import skc_pkg::*;

  logic [LenBits-1:0] klen_q;
  logic [LenBits-1:0] keff;
  logic [KeyBits-1:0] win_q, win_d;
  logic [LenBits-1:0] bases_q, bases_d;
  logic               hdr_q, hdr_d;
  logic               shifted_q, shifted_d;
  logic [KeyBits-1:0] mask;
  logic [KeyBits-1:0] rev_full;
  logic               hdr_start, hdr_end, skip, is_base;
  logic [1:0]         code;

  assign keff = (klen_q == '0) ? LenBits'(1) : ((klen_q > KLenMax) ? KLenMax : klen_q);
  assign mask = (keff >= KLenMax) ? '1 : ((KeyBits'(1) << {keff, 1'b0}) - KeyBits'(1));

  always_comb begin
    is_base = 1'b1;
    code    = 2'd0;
    case (text_byte_i)
      ChA:     code = 2'd0;
      ChT:     code = 2'd1;
      ChG:     code = 2'd2;
      ChC:     code = 2'd3;
      default: is_base = 1'b0;
    endcase
  end

  assign hdr_start = (text_byte_i == ChHeader);
  assign hdr_end   = hdr_q && (text_byte_i == ChNl);
  assign skip      = hdr_d || text_byte_i == ChNl || text_byte_i == ChCr
                     || text_byte_i == ChSpace;

  always_comb begin
    hdr_d = hdr_start ? 1'b1 : (hdr_end ? 1'b0 : hdr_q);
  end

  always_comb begin
    win_d     = win_q;
    bases_d   = bases_q;
    shifted_d = shifted_q;
    if (cfg_we_i) begin
      win_d   = '0;
      bases_d = '0;
    end else if (byte_we_i) begin
      shifted_d = 1'b0;
      if (hdr_start || hdr_end) begin
        win_d   = '0;
        bases_d = '0;
      end
      if (!skip) begin
        if (is_base) begin
          win_d     = ({win_q[KeyBits-3:0], code}) & mask;
          bases_d   = (bases_q < keff) ? bases_q + LenBits'(1) : keff;
          shifted_d = 1'b1;
        end else begin
          win_d   = '0;
          bases_d = '0;
        end
      end
    end
  end

  // base j of the full reverse is base 31-j of the window, complemented
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      rev_full[2*j +: 2] = win_q[2*(31-j) +: 2] ^ 2'b01;
    end
  end

  assign stat_o.window   = win_q;
  assign stat_o.rev_comp = rev_full >> {(KLenMax - keff), 1'b0};
  assign stat_o.full     = (bases_q >= keff);
  assign stat_o.shifted  = shifted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q    <= KLenReset;
      win_q     <= '0;
      bases_q   <= '0;
      hdr_q     <= 1'b0;
      shifted_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_len_i;
      end
      if (byte_we_i && !cfg_we_i) begin
        hdr_q <= hdr_d;
      end
      win_q     <= win_d;
      bases_q   <= bases_d;
      shifted_q <= shifted_d;
    end
  end

endmodule

### hw/rtl/selected_kmer_counter.sv
// Top level of the selected k-mer counter: controller, key and count tables.
// Depends on skc_pkg, skc_ram and skc_window.
//
//  channel | direction | payload      | handshake
//  in      | input     | in_item_t    | in_valid_i / in_ready_o
//  out     | output    | out_item_t   | out_valid_o / out_ready_i
//  cfg     | input     | k-mer length | cfg_valid_i / cfg_ready_o
//
// A table search reads the used key slots in turn, each read in S_SCAN_RD and
// compared in S_SCAN_CMP; a matching base then searches its reverse complement.
// Tables need no clearing after reset: slots below the fill count are valid.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
module selected_kmer_counter #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output skc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_data_i
);
  import skc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_WSTART, S_SCAN_RD, S_SCAN_CMP, S_CNT_RD, S_CNT_WR, S_ENT, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LOAD, PH_WIN, PH_RC
  } phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [AW:0]     scan_q, scan_d;
  logic [AW:0]     used_q, used_d;
  logic [AW-1:0]   slot_q, slot_d;
  logic [KeyBits-1:0] tgt_q, tgt_d;
  logic [1:0]      status_q, status_d;
  logic            hit_q, hit_d;
  logic [63:0]     ekey_q, ekey_d;
  logic [31:0]     ecnt_q, ecnt_d;
  logic            evalid_q, evalid_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            in_acc;
  logic            table_full;
  logic [AW-1:0]   rd_addr;
  logic            key_we, cnt_we;
  logic [AW-1:0]   key_waddr, cnt_waddr;
  logic [KeyBits-1:0] key_wdata, key_rdata;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [63:0]     cnt_wide;
  win_stat_t       win;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign table_full  = (used_q == (AW+1)'(TABLE_ENTRIES));
  assign cnt_wide    = 64'(cnt_rdata);

  skc_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_len_i   (cfg_data_i),
    .byte_we_i   (in_acc && in_data_i.mode == ModeStream),
    .text_byte_i (in_data_i.text_byte),
    .stat_o      (win)
  );

  skc_ram #(.WIDTH(KeyBits), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  skc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = AW'(in_data_i.entry_index);
    end else if (state_q == S_CNT_RD) begin
      rd_addr = slot_q;
    end else begin
      rd_addr = scan_q[AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    scan_d      = scan_q;
    used_d      = used_q;
    slot_d      = slot_q;
    tgt_d       = tgt_q;
    status_d    = status_q;
    hit_d       = hit_q;
    ekey_d      = ekey_q;
    ecnt_d      = ecnt_q;
    evalid_d    = evalid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    key_waddr   = used_q[AW-1:0];
    cnt_waddr   = used_q[AW-1:0];
    key_wdata   = tgt_q;
    cnt_wdata   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = StatusOk;
          hit_d    = 1'b0;
          ekey_d   = '0;
          ecnt_d   = '0;
          evalid_d = 1'b0;
          scan_d   = '0;
          case (in_data_i.mode)
            ModeLoad: begin
              tgt_d   = in_data_i.load_key;
              phase_d = PH_LOAD;
              state_d = S_SCAN_RD;
            end
            ModeStream: state_d = S_WSTART;
            ModeRead: begin
              state_d = (32'(in_data_i.entry_index) < 32'(used_q)) ? S_ENT : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_WSTART: begin
        if (win.shifted && win.full) begin
          tgt_d   = win.window;
          phase_d = PH_WIN;
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_RD: begin
        if (scan_q == used_q) begin
          // miss: loads and complements insert at the fill point
          state_d = S_DONE;
          if (phase_q == PH_LOAD || phase_q == PH_RC) begin
            if (table_full) begin
              status_d = (phase_q == PH_LOAD) ? StatusFull : StatusDrop;
            end else begin
              key_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = (phase_q == PH_RC) ? COUNT_BITS'(1) : '0;
              used_d    = used_q + (AW+1)'(1);
            end
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (key_rdata == tgt_q) begin
          slot_d = scan_q[AW-1:0];
          if (phase_q == PH_LOAD) begin
            cnt_we    = 1'b1;
            cnt_waddr = scan_q[AW-1:0];
            cnt_wdata = '0;
            state_d   = S_DONE;
          end else begin
            if (phase_q == PH_WIN) begin
              hit_d = 1'b1;
            end
            state_d = S_CNT_RD;
          end
        end else begin
          scan_d  = scan_q + (AW+1)'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_CNT_RD: state_d = S_CNT_WR;
      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = slot_q;
        cnt_wdata = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
        if (phase_q == PH_WIN) begin
          phase_d = PH_RC;
          tgt_d   = win.rev_comp;
          scan_d  = '0;
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ENT: begin
        ekey_d   = key_rdata;
        ecnt_d   = cnt_wide[31:0];
        evalid_d = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status       = status_q;
          out_d.hit          = hit_q;
          out_d.window_value = win.window;
          out_d.window_full  = win.full;
          out_d.entry_key    = ekey_q;
          out_d.entry_count  = ecnt_q;
          out_d.entry_valid  = evalid_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_LOAD;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    slot_q   <= slot_d;
    tgt_q    <= tgt_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    ekey_q   <= ekey_d;
    ecnt_q   <= ecnt_d;
    evalid_q <= evalid_d;
    out_q    <= out_d;
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (AW+1)'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_key_write_at_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (!table_full && key_waddr == used_q[AW-1:0]))
    else $error("key written away from the fill point");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction not started");

  a_hit_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> out_q.window_full)
    else $error("hit reported on a partial window");

endmodule
